// ===== rtl/bmrb_pkg.sv =====
// shared types, constants and helper functions for the byte mailbox ring buffer
package bmrb_pkg;

    localparam int DEPTH   = 1024;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int FILL_W  = IDX_W + 1;
    localparam int OFF_W   = 10;
    localparam int SUM_W   = ((IDX_W > OFF_W) ? IDX_W : OFF_W) + 1;
    localparam int CAP_W   = 11;
    localparam int CNT_W   = 11;
    localparam int SHORT_W = 16;

    localparam logic [SHORT_W-1:0] SHORT_MAX = '1;
    localparam logic [FILL_W-1:0]  CAP_RESET = FILL_W'((DEPTH < 1024) ? DEPTH : 1024);

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [FILL_W-1:0]  t_fill;
    typedef logic [CAP_W-1:0]   t_cap;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [SHORT_W-1:0] t_short;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_OWPUT = 2'd1,
        REQ_GET   = 2'd2,
        REQ_PEEK  = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type          req_type;
        logic [7:0]         data_in;
        logic [OFF_W-1:0]   peek_offset;
        logic               end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_out;
        logic       data_valid;
        logic       overwrote;
        t_count     used_count;
        t_count     free_count;
        logic       message_done;
        t_short     message_shortfall;
    } t_out_item;

    typedef struct packed {
        logic       we;
        t_idx       waddr;
        logic [7:0] wdata;
        logic       re;
        t_idx       raddr;
    } t_mem_cmd;

    // zero acts as one, anything above the store depth acts as the depth
    function automatic t_fill cap_clamp(t_cap c);
        if (c == '0) return FILL_W'(1);
        if (32'(c) > DEPTH) return FILL_W'(DEPTH);
        return FILL_W'(c);
    endfunction

    // ring index advance with wrap at the effective capacity
    function automatic t_idx next_idx(t_idx i, t_fill cap);
        t_fill n;
        n = FILL_W'(i) + FILL_W'(1);
        if (n >= cap) return '0;
        return n[IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/bmrb_store.sv =====
// byte store: one write port, one read port with registered read data
module bmrb_store (
    input  logic              i_clk,
    input  bmrb_pkg::t_mem_cmd i_cmd,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [bmrb_pkg::DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        if (i_cmd.re) begin
            r_rdata <= r_mem[i_cmd.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bmrb_ring.sv =====
// ring pointers, fill and shortfall counters, store commands and result fields
module bmrb_ring (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_step,
    input  bmrb_pkg::t_fill       i_cap,
    input  bmrb_pkg::t_in_item    i_req,
    output bmrb_pkg::t_mem_cmd    o_mem,
    output logic                  o_rd,
    output bmrb_pkg::t_out_item   o_res
);

    bmrb_pkg::t_idx   r_ridx, n_ridx;
    bmrb_pkg::t_idx   r_widx, n_widx;
    bmrb_pkg::t_fill  r_fill, n_fill;
    bmrb_pkg::t_short r_short, n_short;

    logic                        valid;
    logic                        drop;
    bmrb_pkg::t_short            report;
    bmrb_pkg::t_mem_cmd          mem;
    logic [bmrb_pkg::SUM_W-1:0]  peek_sum;
    logic [bmrb_pkg::SUM_W-1:0]  peek_addr;

    always_comb begin
        n_ridx  = r_ridx;
        n_widx  = r_widx;
        n_fill  = r_fill;
        valid   = 1'b0;
        drop    = 1'b0;
        mem     = '0;
        o_rd    = 1'b0;

        // peek address wraps once at most since offset stays below the fill
        peek_sum  = bmrb_pkg::SUM_W'(r_ridx) + bmrb_pkg::SUM_W'(i_req.peek_offset);
        peek_addr = (peek_sum >= bmrb_pkg::SUM_W'(i_cap))
                  ? peek_sum - bmrb_pkg::SUM_W'(i_cap) : peek_sum;

        unique case (i_req.req_type)
            bmrb_pkg::REQ_PUT: begin
                if (r_fill < i_cap) begin
                    mem.we    = 1'b1;
                    mem.waddr = r_widx;
                    mem.wdata = i_req.data_in;
                    n_widx    = bmrb_pkg::next_idx(r_widx, i_cap);
                    n_fill    = r_fill + 1'b1;
                    valid     = 1'b1;
                end
            end
            bmrb_pkg::REQ_OWPUT: begin
                if (r_fill >= i_cap) begin
                    n_ridx = bmrb_pkg::next_idx(r_ridx, i_cap);
                    drop   = 1'b1;
                end else begin
                    n_fill = r_fill + 1'b1;
                end
                mem.we    = 1'b1;
                mem.waddr = r_widx;
                mem.wdata = i_req.data_in;
                n_widx    = bmrb_pkg::next_idx(r_widx, i_cap);
                valid     = 1'b1;
            end
            bmrb_pkg::REQ_GET: begin
                if (r_fill != '0) begin
                    mem.re    = 1'b1;
                    mem.raddr = r_ridx;
                    n_ridx    = bmrb_pkg::next_idx(r_ridx, i_cap);
                    n_fill    = r_fill - 1'b1;
                    valid     = 1'b1;
                    o_rd      = 1'b1;
                end
            end
            bmrb_pkg::REQ_PEEK: begin
                if (bmrb_pkg::SUM_W'(i_req.peek_offset) < bmrb_pkg::SUM_W'(r_fill)) begin
                    mem.re    = 1'b1;
                    mem.raddr = peek_addr[bmrb_pkg::IDX_W-1:0];
                    valid     = 1'b1;
                    o_rd      = 1'b1;
                end
            end
            default: begin
                valid = 1'b0;
            end
        endcase

        // saturating count of requests that moved no byte
        n_short = r_short;
        if (!valid && r_short != bmrb_pkg::SHORT_MAX) begin
            n_short = r_short + 1'b1;
        end
        report = '0;
        if (i_req.end_of_message) begin
            report  = n_short;
            n_short = '0;
        end

        o_mem    = mem;
        o_mem.we = mem.we & i_step;
        o_mem.re = mem.re & i_step;

        o_res.data_out          = '0;
        o_res.data_valid        = valid;
        o_res.overwrote         = drop;
        o_res.used_count        = bmrb_pkg::t_count'(n_fill);
        o_res.free_count        = bmrb_pkg::t_count'(i_cap - n_fill);
        o_res.message_done      = i_req.end_of_message;
        o_res.message_shortfall = report;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ridx  <= '0;
            r_widx  <= '0;
            r_fill  <= '0;
            r_short <= '0;
        end else if (i_clear) begin
            r_ridx  <= '0;
            r_widx  <= '0;
            r_fill  <= '0;
        end else if (i_step) begin
            r_ridx  <= n_ridx;
            r_widx  <= n_widx;
            r_fill  <= n_fill;
            r_short <= n_short;
        end
    end

endmodule

// ===== rtl/byte_mailbox_ring_buffer_unit.sv =====
// top level of the byte mailbox ring buffer: handshake, capacity register, result register
// result timing: put, overwrite put and refused requests register their result at transfer;
//   get and peek pass the store read register and the read state, with no new request taken
// throughput: one request per cycle for writes and refusals, while results are taken
// reset: synchronous active-low; ring empty, shortfall zero, capacity back to its default;
//   store contents are not cleared, every entry is written before it can be read
module byte_mailbox_ring_buffer_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  bmrb_pkg::t_in_item    i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output bmrb_pkg::t_out_item   o_out_data,
    // capacity register write
    input  logic                  i_cfg_we,
    input  bmrb_pkg::t_cap        i_cfg_wdata
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state               r_state;
    logic                 r_out_valid;
    bmrb_pkg::t_out_item  r_out;
    bmrb_pkg::t_fill      r_eff_cap;

    logic                 in_xfer;
    logic                 rd;
    bmrb_pkg::t_mem_cmd   mem_cmd;
    bmrb_pkg::t_out_item  ring_res;
    logic [7:0]           rdata;

    // a new request needs the control idle and a free result slot,
    // the slot frees up in the same cycle the old result is transferred
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_xfer    = i_in_valid && o_in_ready;

    bmrb_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_we),
        .i_step  (in_xfer),
        .i_cap   (r_eff_cap),
        .i_req   (i_in_data),
        .o_mem   (mem_cmd),
        .o_rd    (rd),
        .o_res   (ring_res)
    );

    bmrb_store u_store (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_eff_cap   <= bmrb_pkg::CAP_RESET;
        end else begin
            // only the clamped capacity matters downstream
            if (i_cfg_we) begin
                r_eff_cap <= bmrb_pkg::cap_clamp(i_cfg_wdata);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_out <= ring_res;
                        if (rd) begin
                            // hold the result back until the store data returns
                            r_state     <= S_READ;
                            r_out_valid <= 1'b0;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end else if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_READ: begin
                    r_out.data_out <= rdata;
                    r_out_valid    <= 1'b1;
                    r_state        <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // result slot is always empty while a store read is in flight
    a_read_slot_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("result pending during store read");

    // a store read completes in the next cycle and presents its result
    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_IDLE && r_out_valid))
        else $error("store read did not complete");

    // a request that moved no byte never returns data
    a_no_data_on_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.data_valid) |-> (o_out_data.data_out == '0))
        else $error("data on refused request");

    // a store read or write is started only together with a request transfer
    a_read_needs_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_cmd.re || mem_cmd.we) |-> in_xfer)
        else $error("store access without transfer");

endmodule
